>>> src/assert_macros.svh
// Assertion macros shared by the controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/psc_pkg.sv
// Package for the clamped PID step: types, codes, saturation helper and the
// control program of the sequencer. No dependencies.
package psc_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd5;

  // Result status codes.
  localparam logic [1:0] STATUS_NORMAL     = 2'd0;
  localparam logic [1:0] STATUS_DT_INVALID = 2'd1;
  localparam logic [1:0] STATUS_CLEARED    = 2'd2;

  // Input operation codes.
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Divider: the numerator is a 33-bit magnitude shifted up by 16 bits.
  localparam int unsigned DIV_NUM_W = 49;
  localparam int unsigned DIV_ITERS = DIV_NUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);

  // Sequencer program counter.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_TEST_CLEAR = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TEST_DT    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LOAD_P     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ACC_INT    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_I      = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADD_I      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIV_WAIT   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MUL_D      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ADD_D      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT_STEP  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMIT_CLEAR = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT_DTZ   = 4'd11;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_SAT_LOAD,
    UOP_SAT_ADD,
    UOP_ACC_INT,
    UOP_EMIT_STEP,
    UOP_EMIT_CLEAR,
    UOP_EMIT_DTZ
  } uop_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,
    MUL_ERRDT,
    MUL_I,
    MUL_D
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_CLEAR,
    COND_DTZ,
    COND_FIRST,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_e;

  typedef struct packed {
    uop_e              op;
    mul_sel_e          mul;
    logic              div_start;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Saturate a 49-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v[48:31] == '0 || v[48:31] == '1) begin
      r = v[31:0];
    end else if (v[48]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic ucode_word_t uw(input uop_e op, input mul_sel_e mul,
                                     input logic ds, input cond_e cond,
                                     input logic [STEP_W-1:0] target,
                                     input logic last);
    ucode_word_t w;
    w.op        = op;
    w.mul       = mul;
    w.div_start = ds;
    w.cond      = cond;
    w.target    = target;
    w.last      = last;
    return w;
  endfunction

  // Control program. The product of a multiply step is ready in the next step.
  function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] pc);
    ucode_word_t w;
    unique case (pc)
      STEP_TEST_CLEAR:
        w = uw(UOP_NOP, MUL_NONE, 1'b0, COND_CLEAR, STEP_EMIT_CLEAR, 1'b0);
      STEP_TEST_DT:
        w = uw(UOP_NOP, MUL_P, 1'b0, COND_DTZ, STEP_EMIT_DTZ, 1'b0);
      STEP_LOAD_P:
        w = uw(UOP_SAT_LOAD, MUL_ERRDT, 1'b1, COND_NONE, STEP_TEST_CLEAR, 1'b0);
      STEP_ACC_INT:
        w = uw(UOP_ACC_INT, MUL_NONE, 1'b0, COND_NONE, STEP_TEST_CLEAR, 1'b0);
      STEP_MUL_I:
        w = uw(UOP_NOP, MUL_I, 1'b0, COND_NONE, STEP_TEST_CLEAR, 1'b0);
      STEP_ADD_I:
        w = uw(UOP_SAT_ADD, MUL_NONE, 1'b0, COND_FIRST, STEP_EMIT_STEP, 1'b0);
      STEP_DIV_WAIT:
        w = uw(UOP_NOP, MUL_NONE, 1'b0, COND_DIV_BUSY, STEP_DIV_WAIT, 1'b0);
      STEP_MUL_D:
        w = uw(UOP_NOP, MUL_D, 1'b0, COND_NONE, STEP_TEST_CLEAR, 1'b0);
      STEP_ADD_D:
        w = uw(UOP_SAT_ADD, MUL_NONE, 1'b0, COND_NONE, STEP_TEST_CLEAR, 1'b0);
      STEP_EMIT_STEP:
        w = uw(UOP_EMIT_STEP, MUL_NONE, 1'b0, COND_OUT_FULL, STEP_EMIT_STEP, 1'b1);
      STEP_EMIT_CLEAR:
        w = uw(UOP_EMIT_CLEAR, MUL_NONE, 1'b0, COND_OUT_FULL, STEP_EMIT_CLEAR, 1'b1);
      STEP_EMIT_DTZ:
        w = uw(UOP_EMIT_DTZ, MUL_NONE, 1'b0, COND_OUT_FULL, STEP_EMIT_DTZ, 1'b1);
      default:
        w = uw(UOP_NOP, MUL_NONE, 1'b0, COND_NONE, STEP_TEST_CLEAR, 1'b1);
    endcase
    return w;
  endfunction

endpackage

>>> src/psc_div.sv
// Iterative restoring divider for the derivative term: (diff * 2^16) / dt,
// truncated toward zero and saturated to 32 bits. Depends on psc_pkg.
module psc_div
  import psc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] diff_i,
  input  logic        [23:0] dt_i,
  output div_sts_t           sts_o,
  output logic signed [31:0] deriv_o
);

  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_FIX} div_state_e;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_ITERS - 1);

  div_state_e             state_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   done_q;
  logic signed [31:0]     deriv_q;
  logic [DIV_NUM_W-1:0]   work_q;
  logic [23:0]            rem_q;
  logic [23:0]            dt_q;
  logic                   neg_q;

  logic [32:0]            mag;
  logic [24:0]            shifted;
  logic [24:0]            sub;
  logic                   ge;
  logic                   pos_ovf;
  logic                   neg_ovf;
  logic signed [31:0]     deriv_d;

  // Magnitude of the numerator; the divisor is always positive.
  assign mag = diff_i[32] ? (~diff_i + 33'd1) : diff_i;

  // One quotient bit per cycle.
  assign shifted = {rem_q, work_q[DIV_NUM_W-1]};
  assign ge      = shifted >= {1'b0, dt_q};
  assign sub     = shifted - {1'b0, dt_q};

  // Apply the sign and saturate the quotient.
  assign pos_ovf = |work_q[DIV_NUM_W-1:31];
  assign neg_ovf = (|work_q[DIV_NUM_W-1:32]) | (work_q[31] & (|work_q[30:0]));
  always_comb begin
    if (neg_q) begin
      deriv_d = neg_ovf ? 32'sh8000_0000 : $signed(~work_q[31:0] + 32'd1);
    end else begin
      deriv_d = pos_ovf ? 32'sh7FFF_FFFF : $signed(work_q[31:0]);
    end
  end

  // Control state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      deriv_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DIV_IDLE: begin
          if (start_i) begin
            state_q <= DIV_RUN;
            cnt_q   <= '0;
          end
        end
        DIV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_LAST) begin
            state_q <= DIV_FIX;
          end
        end
        DIV_FIX: begin
          deriv_q <= deriv_d;
          done_q  <= 1'b1;
          state_q <= DIV_IDLE;
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      work_q <= {mag, 16'd0};
      rem_q  <= '0;
      dt_q   <= dt_i;
      neg_q  <= diff_i[32];
    end else if (state_q == DIV_RUN) begin
      work_q <= {work_q[DIV_NUM_W-2:0], ge};
      rem_q  <= ge ? sub[23:0] : shifted[23:0];
    end
  end

  assign sts_o.busy = (state_q != DIV_IDLE);
  assign sts_o.done = done_q;
  assign deriv_o    = deriv_q;

endmodule

>>> src/pid_step_clamped.sv
// Top level of the clamped PID step: configuration registers, microcoded
// sequencer, shared multiplier and output register. Uses psc_pkg, psc_div.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  s_axis   | in        | tvalid / tready        | tdata: error, dt; tuser: op
//  m_axis   | out       | tvalid / tready        | tdata: drive; tuser: status
//  cfg      | in        | cfg_we_i (no stall)    | cfg_idx_i, cfg_wdata_i
//
// One request is worked on at a time. A normal step waits on the divider for
// the derivative term, which sets its length. The first step after a clear
// skips the divider, and a zero dt and a clear jump straight to their final
// steps. A finished result waits in the output register while the next
// request is taken; a stalled output holds the sequencer at its final step.
// Reset clears the state, the sequencer and the output valid.
`include "assert_macros.svh"

module pid_step_clamped
  import psc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  // Requests.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,  // [31:0] error, [55:32] dt
  input  logic                 s_axis_tuser,  // [0] op
  // Results.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // [31:0] drive
  output logic [1:0]           m_axis_tuser   // [1:0] step_status
);

  // Configuration.
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, drive_min_q, drive_max_q;
  logic        [30:0] limit_q;

  // Controller state.
  logic signed [31:0] integ_q;
  logic signed [31:0] last_q;
  logic               first_q;

  // Sequencer.
  logic               running_q;
  logic [STEP_W-1:0]  pc_q;
  ucode_word_t        cw;
  logic               jump;

  // Datapath.
  logic               op_q;
  logic signed [31:0] err_q;
  logic        [23:0] dt_q;
  logic signed [31:0] sum_q;
  logic signed [63:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic signed [47:0] term;
  logic signed [48:0] term_ext;
  logic signed [31:0] sat_term;
  logic signed [48:0] add_s;
  logic signed [48:0] acc;
  logic signed [48:0] lim;
  logic signed [48:0] acc_clamped;
  logic signed [31:0] drive_hi;
  logic signed [31:0] drive_v;
  logic signed [32:0] diff;
  logic signed [31:0] deriv;
  div_sts_t           div_sts;
  logic               div_start;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] drive_q;
  logic [1:0]         status_q;

  logic               in_fire;
  logic               slot_free;
  logic               emit;

  assign s_axis_tready = !running_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign cw            = ucode_rom(pc_q);
  assign emit          = running_q && slot_free &&
                         (cw.op inside {UOP_EMIT_STEP, UOP_EMIT_CLEAR, UOP_EMIT_DTZ});

  // Jump condition of the current control word.
  always_comb begin
    unique case (cw.cond)
      COND_NONE:     jump = 1'b0;
      COND_CLEAR:    jump = (op_q == OP_CLEAR);
      COND_DTZ:      jump = (dt_q == '0);
      COND_FIRST:    jump = first_q;
      COND_DIV_BUSY: jump = div_sts.busy;
      COND_OUT_FULL: jump = !slot_free;
      default:       jump = 1'b0;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cw.mul)
      MUL_P: begin
        mul_a = {gain_p_q[31], gain_p_q};
        mul_b = {err_q[31], err_q};
      end
      MUL_ERRDT: begin
        mul_a = {err_q[31], err_q};
        mul_b = $signed({9'd0, dt_q});
      end
      MUL_I: begin
        mul_a = {gain_i_q[31], gain_i_q};
        mul_b = {integ_q[31], integ_q};
      end
      MUL_D: begin
        mul_a = {gain_d_q[31], gain_d_q};
        mul_b = {deriv[31], deriv};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_full = mul_a * mul_b;

  // Floor of the product in Q16.16 and the saturating adds.
  assign term     = prod_q[63:16];
  assign term_ext = {term[47], term};
  assign sat_term = sat32(term_ext);
  assign add_s    = {{17{sum_q[31]}}, sum_q} + {{17{sat_term[31]}}, sat_term};

  // Integral update with magnitude clamp.
  assign acc = {{17{integ_q[31]}}, integ_q} + term_ext;
  assign lim = $signed({18'd0, limit_q});
  always_comb begin
    if (acc > lim) begin
      acc_clamped = lim;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc;
    end
  end

  // Output clamp; the lower bound wins when the bounds are inverted.
  assign drive_hi = (sum_q > drive_max_q) ? drive_max_q : sum_q;
  assign drive_v  = (drive_hi < drive_min_q) ? drive_min_q : drive_hi;

  // Derivative divider, started only when the derivative is used.
  assign diff      = {err_q[31], err_q} - {last_q[31], last_q};
  assign div_start = running_q && cw.div_start && !first_q;

  psc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff),
    .dt_i    (dt_q),
    .sts_o   (div_sts),
    .deriv_o (deriv)
  );

  // Configuration, controller state, sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      drive_min_q <= 32'sh8000_0000;
      drive_max_q <= 32'sh7FFF_FFFF;
      limit_q     <= 31'h7FFF_FFFF;
      integ_q     <= '0;
      last_q      <= '0;
      first_q     <= 1'b1;
      running_q   <= 1'b0;
      pc_q        <= STEP_TEST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN_P:    gain_p_q    <= cfg_wdata_i;
          REG_GAIN_I:    gain_i_q    <= cfg_wdata_i;
          REG_GAIN_D:    gain_d_q    <= cfg_wdata_i;
          REG_DRIVE_MIN: drive_min_q <= cfg_wdata_i;
          REG_DRIVE_MAX: drive_max_q <= cfg_wdata_i;
          REG_INT_LIMIT: limit_q     <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end

      if (running_q) begin
        unique case (cw.op)
          UOP_ACC_INT: integ_q <= acc_clamped[31:0];
          UOP_EMIT_STEP: begin
            if (slot_free) begin
              last_q  <= err_q;
              first_q <= 1'b0;
            end
          end
          UOP_EMIT_CLEAR: begin
            if (slot_free) begin
              integ_q <= '0;
              last_q  <= '0;
              first_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (in_fire) begin
        running_q <= 1'b1;
        pc_q      <= STEP_TEST_CLEAR;
      end else if (running_q) begin
        if (jump) begin
          pc_q <= cw.target;
        end else if (cw.last) begin
          running_q <= 1'b0;
        end else begin
          pc_q <= pc_q + 1'b1;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, working registers and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tuser;
      err_q <= s_axis_tdata[31:0];
      dt_q  <= s_axis_tdata[55:32];
    end
    if (running_q) begin
      if (cw.mul != MUL_NONE) begin
        prod_q <= prod_full[63:0];
      end
      case (cw.op)
        UOP_SAT_LOAD: sum_q <= sat_term;
        UOP_SAT_ADD:  sum_q <= sat32(add_s);
        default: ;
      endcase
      if (emit) begin
        case (cw.op)
          UOP_EMIT_STEP: begin
            drive_q  <= drive_v;
            status_q <= STATUS_NORMAL;
          end
          UOP_EMIT_CLEAR: begin
            drive_q  <= '0;
            status_q <= STATUS_CLEARED;
          end
          default: begin
            drive_q  <= '0;
            status_q <= STATUS_DT_INVALID;
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;
  assign m_axis_tuser  = status_q;

  // Assertions.
  logic signed [32:0] integ_ext;
  logic signed [32:0] lim_ext;
  assign integ_ext = {integ_q[31], integ_q};
  assign lim_ext   = $signed({2'b00, limit_q});

  `PSC_ASSERT(a_div_done_at_wait, div_sts.done |-> (running_q && pc_q == STEP_DIV_WAIT), "divider finished outside its wait step")
  `PSC_ASSERT(a_integ_bounded, (running_q && cw.op == UOP_ACC_INT) |=> ((integ_ext <= lim_ext) && (integ_ext >= -lim_ext)), "integral left its bound")
  `PSC_ASSERT(a_result_from_emit, $rose(out_valid_q) |-> $past(running_q && cw.last), "result appeared without a final step")

endmodule
